// ===== rtl/core/bdt_pkg.sv =====
`timescale 1ns / 1ps

package bdt_pkg;

  localparam int unsigned ToneW     = 20;
  localparam int unsigned DurW      = 8;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned FrameBits = 8;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CodeW-1:0] CodeFigs = 5'h1b;
  localparam logic [CodeW-1:0] CodeLtrs = 5'h1f;

  localparam logic [ToneW-1:0] MarkToneRst  = 20'd2125;
  localparam logic [ToneW-1:0] SpaceToneRst = 20'd1955;
  localparam logic [DurW-1:0]  DurRst       = 8'd22;

  localparam logic [CfgIdxW-1:0] CfgMarkTone  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpaceTone = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBitDur    = 2'd2;

  typedef struct packed {
    logic             hit;
    logic             figs;
    logic             keep_shift;
    logic [CodeW-1:0] code;
  } lookup_t;

  // bits are sent msb first; dbl set when a shift frame precedes the char frame
  typedef struct packed {
    logic [2*FrameBits-1:0] bits;
    logic                   dbl;
  } frame_t;

  function automatic logic [CodeW-1:0] figs_code(input logic [CharW-1:0] ch,
                                                  output logic hit);
    logic [CodeW-1:0] c;
    hit = 1'b1;
    c   = '0;
    case (ch)
      8'h20: c = 5'h04;
      8'h0d: c = 5'h08;
      8'h0a: c = 5'h02;
      8'h31: c = 5'h1d;
      8'h32: c = 5'h19;
      8'h33: c = 5'h10;
      8'h34: c = 5'h0a;
      8'h35: c = 5'h01;
      8'h36: c = 5'h15;
      8'h37: c = 5'h1c;
      8'h38: c = 5'h0c;
      8'h39: c = 5'h03;
      8'h30: c = 5'h0d;
      8'h2d: c = 5'h18;
      8'h07: c = 5'h14;
      8'h40: c = 5'h12;
      8'h21: c = 5'h16;
      8'h26: c = 5'h0b;
      8'h23: c = 5'h05;
      8'h27: c = 5'h1a;
      8'h28: c = 5'h1e;
      8'h29: c = 5'h09;
      8'h22: c = 5'h11;
      8'h2f: c = 5'h17;
      8'h3a: c = 5'h0e;
      8'h3b: c = 5'h0f;
      8'h3f: c = 5'h13;
      8'h2c: c = 5'h06;
      8'h2e: c = 5'h07;
      default: hit = 1'b0;
    endcase
    return c;
  endfunction

  function automatic logic [CodeW-1:0] ltrs_code(input logic [CharW-1:0] ch,
                                                  output logic hit);
    logic [CodeW-1:0] c;
    hit = 1'b1;
    c   = '0;
    case (ch)
      8'h51: c = 5'h1d;
      8'h57: c = 5'h19;
      8'h45: c = 5'h10;
      8'h52: c = 5'h0a;
      8'h54: c = 5'h01;
      8'h59: c = 5'h15;
      8'h55: c = 5'h1c;
      8'h49: c = 5'h0c;
      8'h4f: c = 5'h03;
      8'h50: c = 5'h0d;
      8'h41: c = 5'h18;
      8'h53: c = 5'h14;
      8'h44: c = 5'h12;
      8'h46: c = 5'h16;
      8'h47: c = 5'h0b;
      8'h48: c = 5'h05;
      8'h4a: c = 5'h1a;
      8'h4b: c = 5'h1e;
      8'h4c: c = 5'h09;
      8'h5a: c = 5'h11;
      8'h58: c = 5'h17;
      8'h43: c = 5'h0e;
      8'h56: c = 5'h0f;
      8'h42: c = 5'h13;
      8'h4e: c = 5'h06;
      8'h4d: c = 5'h07;
      default: hit = 1'b0;
    endcase
    return c;
  endfunction

  function automatic lookup_t lookup_char(input logic [CharW-1:0] ch);
    lookup_t          r;
    logic             fhit;
    logic             lhit;
    logic [CodeW-1:0] fcode;
    logic [CodeW-1:0] lcode;
    logic [CharW-1:0] up;
    fcode = figs_code(ch, fhit);
    up    = ((ch >= 8'h61) && (ch <= 8'h7a)) ? (ch - 8'h20) : ch;
    lcode = ltrs_code(up, lhit);
    r.hit        = fhit | lhit;
    r.figs       = fhit;
    r.code       = fhit ? fcode : lcode;
    // space, cr and lf stay in the current shift
    r.keep_shift = fhit && ((ch == 8'h20) || (ch == 8'h0d) || (ch == 8'h0a));
    return r;
  endfunction

endpackage

// ===== rtl/core/bdt_char_if.sv =====
`timescale 1ns / 1ps

interface bdt_char_if;
  import bdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] ascii_char;
  logic             start_of_message;

  modport source (output valid, ascii_char, start_of_message, input ready);
  modport sink (input valid, ascii_char, start_of_message, output ready);
endinterface

// ===== rtl/core/bdt_bit_if.sv =====
`timescale 1ns / 1ps

interface bdt_bit_if;
  import bdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ToneW-1:0] tone_hz;
  logic             line_bit;
  logic [DurW-1:0]  duration_ms;
  logic             last;

  modport source (output valid, tone_hz, line_bit, duration_ms, last, input ready);
  modport sink (input valid, tone_hz, line_bit, duration_ms, last, output ready);
endinterface

// ===== rtl/core/bdt_encode.sv =====
`timescale 1ns / 1ps

module bdt_encode (
  input  logic            clk_i,
  input  logic            rst_ni,
  bdt_char_if.sink        char_i,
  output logic            frm_valid_o,
  output bdt_pkg::frame_t frm_o,
  input  logic            frm_ready_i
);
  import bdt_pkg::*;

  typedef enum logic [1:0] {
    ShiftNone = 2'd0,
    ShiftFigs = 2'd1,
    ShiftLtrs = 2'd2
  } shift_e;

  shift_e  shift_q, shift_d, mode, need;
  logic    frm_valid_q, frm_valid_d;
  frame_t  frm_q, frm_d;
  lookup_t lk;
  logic    accept;
  logic    send_shift;
  logic [FrameBits-1:0] char_fr;
  logic [FrameBits-1:0] shift_fr;

  assign char_i.ready = !frm_valid_q || frm_ready_i;
  assign accept       = char_i.valid && char_i.ready;

  always_comb begin
    lk         = lookup_char(char_i.ascii_char);
    mode       = char_i.start_of_message ? ShiftNone : shift_q;
    need       = lk.figs ? ShiftFigs : ShiftLtrs;
    send_shift = lk.hit && !lk.keep_shift && (mode != need);
    char_fr    = {1'b0, lk.code, 2'b11};
    shift_fr   = {1'b0, (lk.figs ? CodeFigs : CodeLtrs), 2'b11};
    frm_d.dbl  = send_shift;
    frm_d.bits = send_shift ? {shift_fr, char_fr} : {char_fr, {FrameBits{1'b1}}};

    shift_d     = shift_q;
    frm_valid_d = frm_valid_q;
    if (accept) begin
      shift_d     = (lk.hit && !lk.keep_shift) ? need : mode;
      frm_valid_d = lk.hit;
    end else if (frm_ready_i) begin
      frm_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= ShiftNone;
      frm_valid_q <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frm_q <= frm_d;
    end
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

// ===== rtl/core/bdt_shifter.sv =====
`timescale 1ns / 1ps

module bdt_shifter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     frm_valid_i,
  input  bdt_pkg::frame_t          frm_i,
  output logic                     frm_ready_o,
  input  logic [bdt_pkg::ToneW-1:0] mark_tone_i,
  input  logic [bdt_pkg::ToneW-1:0] space_tone_i,
  input  logic [bdt_pkg::DurW-1:0]  bit_dur_i,
  bdt_bit_if.source                bit_o
);
  import bdt_pkg::*;

  localparam int unsigned CntW = $clog2(2 * FrameBits + 1);

  logic [2*FrameBits-1:0] sh_q, sh_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   bit_q, last_q;
  logic [ToneW-1:0]       tone_q;
  logic [DurW-1:0]        dur_q;
  logic                   adv;
  logic                   load;

  assign adv         = (cnt_q != '0) && (!out_valid_q || bit_o.ready);
  assign frm_ready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && adv);
  assign load        = frm_valid_i && frm_ready_o;

  always_comb begin
    sh_d        = sh_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      sh_d  = {sh_q[2*FrameBits-2:0], 1'b1};
      cnt_d = cnt_q - CntW'(1);
    end
    if (load) begin
      sh_d  = frm_i.bits;
      cnt_d = frm_i.dbl ? CntW'(2 * FrameBits) : CntW'(FrameBits);
    end
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (bit_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (adv) begin
      bit_q  <= sh_q[2*FrameBits-1];
      last_q <= (cnt_q == CntW'(1));
      tone_q <= sh_q[2*FrameBits-1] ? mark_tone_i : space_tone_i;
      dur_q  <= bit_dur_i;
    end
  end

  assign bit_o.valid       = out_valid_q;
  assign bit_o.line_bit    = bit_q;
  assign bit_o.last        = last_q;
  assign bit_o.tone_hz     = tone_q;
  assign bit_o.duration_ms = dur_q;

endmodule

// ===== rtl/core/baudot_rtty_char_serializer.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                   transfer
// char_i    in   ascii_char[7:0], start_of_message         valid & ready
// bit_o     out  tone_hz[19:0], line_bit, duration_ms[7:0], last
//                                                          valid & ready
// cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[19:0] write on cfg_we_i
//
// a character gives 8 bits, or 16 when a figs/ltrs shift frame goes first
// the bit shifter sends one bit per cycle while bit_o is not stalled
// the encode stage holds the next character's frame while the shifter is busy
// unknown characters are accepted and give no bits
// reset clears shift mode and all valids; tone and duration go to defaults
// a stall on bit_o holds the output register and backs up to char_i.ready

module baudot_rtty_char_serializer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bdt_pkg::ToneW-1:0]   cfg_data_i,
  bdt_char_if.sink                    char_i,
  bdt_bit_if.source                   bit_o
);
  import bdt_pkg::*;

  logic [ToneW-1:0] mark_q;
  logic [ToneW-1:0] space_q;
  logic [DurW-1:0]  dur_q;
  logic             frm_valid;
  logic             frm_ready;
  frame_t           frm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= MarkToneRst;
      space_q <= SpaceToneRst;
      dur_q   <= DurRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMarkTone:  mark_q  <= cfg_data_i;
        CfgSpaceTone: space_q <= cfg_data_i;
        CfgBitDur:    dur_q   <= cfg_data_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  bdt_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .frm_valid_o (frm_valid),
    .frm_o       (frm),
    .frm_ready_i (frm_ready)
  );

  bdt_shifter u_shifter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frm_valid_i  (frm_valid),
    .frm_i        (frm),
    .frm_ready_o  (frm_ready),
    .mark_tone_i  (mark_q),
    .space_tone_i (space_q),
    .bit_dur_i    (dur_q),
    .bit_o        (bit_o)
  );

  a_frame_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_valid && !frm_ready |=> frm_valid && $stable(frm))
    else $error("frame changed while stalled");

  a_tone_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_o.valid |-> (bit_o.tone_hz == (bit_o.line_bit ? mark_q : space_q))
                    && (bit_o.duration_ms == dur_q))
    else $error("tone or duration does not match configuration");

  a_last_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_o.valid && bit_o.last |-> bit_o.line_bit)
    else $error("last bit of a character is not a stop bit");

endmodule

// ===== bench/tb_rtty_pkg.sv =====
`timescale 1ns / 1ps

package tb_rtty_pkg;
  import bdt_pkg::*;

  localparam int unsigned TableLen = 29;

  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  localparam logic [CharW-1:0] FigsChars [TableLen] = '{
    8'h20, 8'h0d, 8'h0a, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h30, 8'h2d, 8'h07, 8'h40, 8'h21, 8'h26, 8'h23, 8'h27,
    8'h28, 8'h29, 8'h22, 8'h2f, 8'h3a, 8'h3b, 8'h3f, 8'h2c, 8'h2e
  };

  localparam logic [CharW-1:0] LtrsChars [TableLen] = '{
    8'h20, 8'h0d, 8'h0a, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55,
    8'h49, 8'h4f, 8'h50, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a,
    8'h4b, 8'h4c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d
  };

  localparam logic [CodeW-1:0] BaudotCodes [TableLen] = '{
    5'h04, 5'h08, 5'h02, 5'h1d, 5'h19, 5'h10, 5'h0a, 5'h01, 5'h15, 5'h1c,
    5'h0c, 5'h03, 5'h0d, 5'h18, 5'h14, 5'h12, 5'h16, 5'h0b, 5'h05, 5'h1a,
    5'h1e, 5'h09, 5'h11, 5'h17, 5'h0e, 5'h0f, 5'h13, 5'h06, 5'h07
  };

  typedef enum logic [1:0] {
    ShiftNone = 2'd0,
    ShiftFigs = 2'd1,
    ShiftLtrs = 2'd2
  } shift_e;

  typedef struct packed {
    logic [ToneW-1:0] tone;
    logic             line;
    logic [DurW-1:0]  dur;
    logic             last;
  } line_bit_t;

  class rtty_line_tracker;
    logic [ToneW-1:0] mark_hz;
    logic [ToneW-1:0] space_hz;
    logic [DurW-1:0]  bit_ms;
    shift_e           shift;
    line_bit_t        pending_bits[$];
    int unsigned      mismatches;

    function new();
      mark_hz    = MarkToneRst;
      space_hz   = SpaceToneRst;
      bit_ms     = DurRst;
      shift      = ShiftNone;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [ToneW-1:0] data);
      case (idx)
        CfgMarkTone: begin
          mark_hz = data;
        end
        CfgSpaceTone: begin
          space_hz = data;
        end
        CfgBitDur: begin
          bit_ms = data[DurW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int find_pos(input logic [CharW-1:0] ch, input logic in_figs);
      for (int i = 0; i < TableLen; i++) begin
        if ((in_figs ? FigsChars[i] : LtrsChars[i]) == ch) begin
          return i;
        end
      end
      return -1;
    endfunction

    function void push_bit(input logic b, input logic fin);
      line_bit_t e;
      e.tone = b ? mark_hz : space_hz;
      e.line = b;
      e.dur  = bit_ms;
      e.last = fin;
      pending_bits.push_back(e);
    endfunction

    // start bit, five code bits msb first, two stop bits
    function void push_frame(input logic [CodeW-1:0] code, input logic fin);
      push_bit(1'b0, 1'b0);
      for (int i = CodeW - 1; i >= 0; i--) begin
        push_bit(code[i], 1'b0);
      end
      push_bit(1'b1, 1'b0);
      push_bit(1'b1, fin);
    endfunction

    function void take_char(input logic [CharW-1:0] ch, input logic som);
      int               pos;
      logic [CharW-1:0] up;
      logic             in_figs;
      shift_e           need;
      if (som) begin
        shift = ShiftNone;
      end
      pos     = find_pos(ch, 1'b1);
      in_figs = (pos >= 0);
      if (!in_figs) begin
        up  = ((ch >= 8'h61) && (ch <= 8'h7a)) ? ch - 8'h20 : ch;
        pos = find_pos(up, 1'b0);
      end
      if (pos < 0) begin
        return;
      end
      need = in_figs ? ShiftFigs : ShiftLtrs;
      // space, cr and lf never force a shift frame
      if (pos > 2 && shift != need) begin
        shift = need;
        push_frame(in_figs ? CodeFigs : CodeLtrs, 1'b0);
      end
      push_frame(BaudotCodes[pos], 1'b1);
    endfunction

    function void match_bit(input logic [ToneW-1:0] tone, input logic line,
                            input logic [DurW-1:0] dur, input logic last);
      line_bit_t want;
      if (pending_bits.size() == 0) begin
        $error("unexpected bit: tone_hz %0d line_bit %0b duration_ms %0d last %0b",
               tone, line, dur, last);
        mismatches++;
        return;
      end
      want = pending_bits.pop_front();
      if (tone !== want.tone) begin
        $error("tone_hz: expected %0d, got %0d", want.tone, tone);
        mismatches++;
      end
      if (line !== want.line) begin
        $error("line_bit: expected %0b, got %0b", want.line, line);
        mismatches++;
      end
      if (dur !== want.dur) begin
        $error("duration_ms: expected %0d, got %0d", want.dur, dur);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bdt_pkg::*;
  import tb_rtty_pkg::*;

  localparam int unsigned IdleTail       = 24;
  localparam int unsigned QuietLimit     = 4000;
  localparam int unsigned RandomPerPhase = 32;
  localparam int unsigned NumPhases      = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ToneW-1:0]   cfg_data_i;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  rtty_line_tracker tracker;

  bdt_char_if char_bus ();
  bdt_bit_if  bit_bus ();

  baudot_rtty_char_serializer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .char_i     (char_bus),
    .bit_o      (bit_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && bit_bus.valid && bit_bus.ready) begin
      tracker.match_bit(bit_bus.tone_hz, bit_bus.line_bit, bit_bus.duration_ms,
                        bit_bus.last);
    end
    bit_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((char_bus.valid && char_bus.ready) || (bit_bus.valid && bit_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_char(input logic [CharW-1:0] ch, input logic som);
    while ($urandom_range(99) < src_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_bus.valid            <= 1'b1;
    char_bus.ascii_char       <= ch;
    char_bus.start_of_message <= som;
    do @(posedge clk_i); while (!char_bus.ready);
    tracker.take_char(ch, som);
  endtask

  // hold off the sender until every pending bit has gone out
  task automatic drain_bits(input int unsigned tail);
    char_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_bits.size() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ToneW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  function automatic logic [CharW-1:0] pick_char();
    int unsigned sel;
    int unsigned idx;
    sel = $urandom_range(99);
    idx = $urandom_range(TableLen - 1);
    if (sel < 12) begin
      return CharW'($urandom_range(255));
    end else if (sel < 40) begin
      return FigsChars[idx];
    end else if (sel < 70) begin
      return LtrsChars[idx];
    end
    // lower case letters fold onto the letters table
    idx = $urandom_range(TableLen - 1, 3);
    return LtrsChars[idx] + 8'h20;
  endfunction

  initial begin
    tracker        = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_idx_i                 <= CfgMarkTone;
    cfg_data_i                <= '0;
    char_bus.valid            <= 1'b0;
    char_bus.ascii_char       <= '0;
    char_bus.start_of_message <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_char(8'h20, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h0d, 1'b0);
    send_char(8'h0a, 1'b0);
    send_char(8'h31, 1'b0);
    send_char(8'h07, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h2e, 1'b0);
    send_char(8'h7a, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7b, 1'b0);
    send_char(8'h7e, 1'b0);
    send_char(8'h5a, 1'b1);
    send_char(8'h3f, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h3f, 1'b0);
    send_char(8'h20, 1'b1);
    send_char(8'h4d, 1'b0);
    send_char(8'h51, 1'b0);
    send_char(8'h71, 1'b0);
    drain_bits(IdleTail);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 59;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 59;
        end
        default: begin
          src_idle_pct   = 20;
          sink_stall_pct = 20;
        end
      endcase
      case (ph)
        0: begin
          write_reg(CfgMarkTone, 20'hfffff);
          write_reg(CfgSpaceTone, 20'h00000);
          write_reg(CfgBitDur, 20'hfffff);
        end
        1: begin
          write_reg(CfgMarkTone, 20'h00000);
          write_reg(CfgSpaceTone, 20'hfffff);
          // zero duration, upper bits dropped
          write_reg(CfgBitDur, 20'habc00);
        end
        2: begin
          write_reg(CfgNoReg, ToneW'($urandom));
          write_reg(CfgBitDur, {12'($urandom), 8'h01});
        end
        3: begin
          write_reg(CfgMarkTone, MarkToneRst);
          write_reg(CfgSpaceTone, SpaceToneRst);
          write_reg(CfgBitDur, ToneW'(DurRst));
        end
        default: begin
          write_reg(CfgMarkTone, ToneW'($urandom));
          write_reg(CfgSpaceTone, ToneW'($urandom));
          write_reg(CfgBitDur, {12'($urandom), 8'($urandom_range(255, 1))});
          write_reg(CfgNoReg, ToneW'($urandom));
        end
      endcase
      cfg_we_i <= 1'b0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        if ($urandom_range(39) == 0) begin
          drain_bits(0);
        end
        send_char(pick_char(), ($urandom_range(19) == 0));
      end
      drain_bits(IdleTail);
    end

    if (tracker.pending_bits.size() != 0) begin
      $error("%0d expected bits never arrived", tracker.pending_bits.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
